// ===== rtl/slir_pkg.sv =====
// ----------------------------------------------------------------------------
// slir_pkg
// Shared types and codes for the sorted insertion list.
// ----------------------------------------------------------------------------
package slir_pkg;

    localparam int unsigned DATA_W = 32;

    // Operation codes carried in the mode field
    localparam logic [1:0] MODE_INSERT  = 2'd0;
    localparam logic [1:0] MODE_DISPLAY = 2'd1;
    localparam logic [1:0] MODE_ROTATE  = 2'd2;

    // Result status codes
    localparam logic [2:0] ST_SHOWN    = 3'd0;
    localparam logic [2:0] ST_EMPTY    = 3'd1;
    localparam logic [2:0] ST_INSERTED = 3'd2;
    localparam logic [2:0] ST_FULL     = 3'd3;
    localparam logic [2:0] ST_ROTATED  = 3'd4;

    typedef struct packed {
        logic [1:0]               mode;
        logic signed [DATA_W-1:0] value;
    } in_t;

    typedef struct packed {
        logic [2:0]               status;
        logic signed [DATA_W-1:0] entry;
        logic                     last;
    } out_t;

    typedef enum logic [2:0] {
        S_IDLE,
        S_INS,
        S_INS_END,
        S_DISP,
        S_ROT,
        S_EMIT
    } state_t;

endpackage

// ===== rtl/sorted_list_insert_rotate.sv =====
// ----------------------------------------------------------------------------
// sorted_list_insert_rotate
// Bounded ordered list of signed 32-bit values with insert, display, rotate.
// ----------------------------------------------------------------------------
// The list lives in a RAM of two banks with room for DEPTH entries each, one
// write and one registered read port; a count register tracks occupancy. One
// transaction is worked on at a time and the RAM port moves one entry per
// cycle, stalling only in a display while the output is held. An insert
// scans forward and carries the displaced entries up, then writes the tail
// and gives the result; a display delivers one entry per cycle while the
// output is taken; a rotate copies into the idle bank, then swaps banks.
// A full insert, an empty display and a short rotate go straight to the
// result; mode 3 is accepted and dropped with no result. A pending result sits
// in an output register, so the next transaction is accepted while it waits.
// ----------------------------------------------------------------------------
module sorted_list_insert_rotate #(
    parameter int DEPTH = 16
) (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             in_valid,
    output logic             in_ready,
    input  slir_pkg::in_t    in_data,
    output logic             out_valid,
    input  logic             out_ready,
    output slir_pkg::out_t   out_data
);

    localparam int IDX_W  = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W  = $clog2(DEPTH + 1);
    localparam int ADDR_W = IDX_W + 1;

    slir_pkg::state_t state_reg, state_next;

    logic [CNT_W-1:0] count_reg, count_next;
    logic [CNT_W-1:0] idx_reg, idx_next;
    logic [CNT_W-1:0] src_reg, src_next;
    logic             bank_reg, bank_next;
    logic             found_reg, found_next;
    logic [2:0]       pend_reg, pend_next;
    logic             out_valid_reg, out_valid_next;
    slir_pkg::out_t   out_data_reg, out_data_next;
    logic signed [slir_pkg::DATA_W-1:0] carry_reg, carry_next;

    // RAM port signals
    logic                                mem_we;
    logic [ADDR_W-1:0]                   mem_waddr;
    logic signed [slir_pkg::DATA_W-1:0]  mem_wdata;
    logic                                mem_re;
    logic [ADDR_W-1:0]                   mem_raddr;
    logic signed [slir_pkg::DATA_W-1:0]  mem_rdata;

    logic             out_free;
    logic [CNT_W-1:0] idx_inc;
    logic [CNT_W-1:0] src_inc;
    logic             idx_done;
    logic             place;

    // No forwarding is needed: within one operation the write and read
    // addresses of the same cycle always differ (next index or other bank).
    slir_mem #(
        .ADDR_W (ADDR_W)
    ) u_mem (
        .clk   (clk),
        .we    (mem_we),
        .waddr (mem_waddr),
        .wdata (mem_wdata),
        .re    (mem_re),
        .raddr (mem_raddr),
        .rdata (mem_rdata)
    );

    assign out_free  = !out_valid_reg || out_ready;
    assign idx_inc   = idx_reg + CNT_W'(1);
    assign src_inc   = src_reg + CNT_W'(1);
    assign idx_done  = (idx_inc == count_reg);
    assign out_valid = out_valid_reg;
    assign out_data  = out_data_reg;

    // Insert point: before entry 0 if it is greater, else before the first
    // later entry that is not smaller. Once found, every later slot takes
    // the carried entry and the old one moves into the carry.
    assign place = found_reg ||
                   ((idx_reg == '0) ? (carry_reg < mem_rdata) : !(mem_rdata < carry_reg));

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= slir_pkg::S_IDLE;
            count_reg     <= '0;
            bank_reg      <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            count_reg     <= count_next;
            bank_reg      <= bank_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        idx_reg      <= idx_next;
        src_reg      <= src_next;
        found_reg    <= found_next;
        pend_reg     <= pend_next;
        carry_reg    <= carry_next;
        out_data_reg <= out_data_next;
    end

    always_comb
    begin
        state_next     = state_reg;
        count_next     = count_reg;
        idx_next       = idx_reg;
        src_next       = src_reg;
        bank_next      = bank_reg;
        found_next     = found_reg;
        pend_next      = pend_reg;
        carry_next     = carry_reg;
        out_data_next  = out_data_reg;
        out_valid_next = out_valid_reg && !out_ready;

        mem_we    = 1'b0;
        mem_waddr = {bank_reg, idx_reg[IDX_W-1:0]};
        mem_wdata = carry_reg;
        mem_re    = 1'b0;
        mem_raddr = {bank_reg, idx_reg[IDX_W-1:0]};

        in_ready = 1'b0;

        case (state_reg)
            slir_pkg::S_IDLE:
            begin
                in_ready = 1'b1;
                if (in_valid)
                begin
                    case (in_data.mode)
                        slir_pkg::MODE_INSERT:
                        begin
                            if (count_reg == CNT_W'(DEPTH))
                            begin
                                pend_next  = slir_pkg::ST_FULL;
                                state_next = slir_pkg::S_EMIT;
                            end
                            else if (count_reg == '0)
                            begin
                                mem_we     = 1'b1;
                                mem_waddr  = {bank_reg, IDX_W'(0)};
                                mem_wdata  = in_data.value;
                                count_next = CNT_W'(1);
                                pend_next  = slir_pkg::ST_INSERTED;
                                state_next = slir_pkg::S_EMIT;
                            end
                            else
                            begin
                                mem_re     = 1'b1;
                                mem_raddr  = {bank_reg, IDX_W'(0)};
                                idx_next   = '0;
                                carry_next = in_data.value;
                                found_next = 1'b0;
                                state_next = slir_pkg::S_INS;
                            end
                        end
                        slir_pkg::MODE_DISPLAY:
                        begin
                            if (count_reg == '0)
                            begin
                                pend_next  = slir_pkg::ST_EMPTY;
                                state_next = slir_pkg::S_EMIT;
                            end
                            else
                            begin
                                mem_re     = 1'b1;
                                mem_raddr  = {bank_reg, IDX_W'(0)};
                                idx_next   = '0;
                                state_next = slir_pkg::S_DISP;
                            end
                        end
                        slir_pkg::MODE_ROTATE:
                        begin
                            if (count_reg < CNT_W'(2))
                            begin
                                pend_next  = slir_pkg::ST_ROTATED;
                                state_next = slir_pkg::S_EMIT;
                            end
                            else
                            begin
                                // Start the copy at the second half
                                src_next   = count_reg >> 1;
                                mem_re     = 1'b1;
                                mem_raddr  = {bank_reg, src_next[IDX_W-1:0]};
                                idx_next   = '0;
                                state_next = slir_pkg::S_ROT;
                            end
                        end
                        default:
                        begin
                            // Drop the unused mode
                            state_next = slir_pkg::S_IDLE;
                        end
                    endcase
                end
            end

            slir_pkg::S_INS:
            begin
                if (place)
                begin
                    mem_we     = 1'b1;
                    mem_wdata  = carry_reg;
                    carry_next = mem_rdata;
                    found_next = 1'b1;
                end
                if (idx_done)
                begin
                    state_next = slir_pkg::S_INS_END;
                end
                else
                begin
                    mem_re    = 1'b1;
                    mem_raddr = {bank_reg, idx_inc[IDX_W-1:0]};
                    idx_next  = idx_inc;
                end
            end

            slir_pkg::S_INS_END:
            begin
                // Append whatever is left in the carry at the tail
                mem_we     = 1'b1;
                mem_waddr  = {bank_reg, count_reg[IDX_W-1:0]};
                mem_wdata  = carry_reg;
                count_next = count_reg + CNT_W'(1);
                pend_next  = slir_pkg::ST_INSERTED;
                state_next = slir_pkg::S_EMIT;
            end

            slir_pkg::S_DISP:
            begin
                // Hold the read data until the output register frees up
                if (out_free)
                begin
                    out_valid_next       = 1'b1;
                    out_data_next.status = slir_pkg::ST_SHOWN;
                    out_data_next.entry  = mem_rdata;
                    out_data_next.last   = idx_done;
                    if (idx_done)
                    begin
                        state_next = slir_pkg::S_IDLE;
                    end
                    else
                    begin
                        mem_re    = 1'b1;
                        mem_raddr = {bank_reg, idx_inc[IDX_W-1:0]};
                        idx_next  = idx_inc;
                    end
                end
            end

            slir_pkg::S_ROT:
            begin
                mem_we    = 1'b1;
                mem_waddr = {!bank_reg, idx_reg[IDX_W-1:0]};
                mem_wdata = mem_rdata;
                if (idx_done)
                begin
                    bank_next  = !bank_reg;
                    pend_next  = slir_pkg::ST_ROTATED;
                    state_next = slir_pkg::S_EMIT;
                end
                else
                begin
                    src_next  = (src_inc == count_reg) ? '0 : src_inc;
                    mem_re    = 1'b1;
                    mem_raddr = {bank_reg, src_next[IDX_W-1:0]};
                    idx_next  = idx_inc;
                end
            end

            slir_pkg::S_EMIT:
            begin
                if (out_free)
                begin
                    out_valid_next       = 1'b1;
                    out_data_next.status = pend_reg;
                    out_data_next.entry  = '0;
                    out_data_next.last   = 1'b1;
                    state_next           = slir_pkg::S_IDLE;
                end
            end

            default:
            begin
                state_next = slir_pkg::S_IDLE;
            end
        endcase
    end

endmodule

// ===== rtl/slir_mem.sv =====
// ----------------------------------------------------------------------------
// slir_mem
// Simple dual-port RAM: one write port, one read port, registered read data.
// ----------------------------------------------------------------------------
module slir_mem #(
    parameter int ADDR_W = 5
) (
    input  logic                                clk,
    input  logic                                we,
    input  logic [ADDR_W-1:0]                   waddr,
    input  logic signed [slir_pkg::DATA_W-1:0]  wdata,
    input  logic                                re,
    input  logic [ADDR_W-1:0]                   raddr,
    output logic signed [slir_pkg::DATA_W-1:0]  rdata
);

    logic signed [slir_pkg::DATA_W-1:0] mem [2**ADDR_W];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
    end

    // Hold read data while no read is issued
    always_ff @(posedge clk)
    begin
        if (re)
        begin
            rdata <= mem[raddr];
        end
    end

endmodule

// ===== tb/sv/tb_sorted_list_insert_rotate.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_sorted_list_insert_rotate
// Self-checking bench for the bounded sorted insertion list.
// ----------------------------------------------------------------------------
// A driver feeds insert, display and rotate transactions from a queue of
// pending items. Each accepted transaction is applied to a local image of the
// list, which queues the results it must produce. A monitor compares every
// result taken from the block, field by field, with the oldest awaited one.
// The run walks through phases of sender idling and receiver stalling, and
// holds the output off for a long stretch once so the block backs up.
// ----------------------------------------------------------------------------
module tb_sorted_list_insert_rotate;

    localparam int          CLK_PERIOD      = 12;
    localparam int          LIST_DEPTH      = 16;
    localparam int          HOLD_OFF_CYCLES = 300;
    localparam int          SETTLE_CYCLES   = 2 * LIST_DEPTH + 8;
    localparam int          PHASE_ITEMS     = 100;
    // The block accepts this code and drops it without a result
    localparam logic [1:0]  MODE_UNUSED     = 2'd3;

    localparam logic signed [slir_pkg::DATA_W-1:0] VAL_MIN = 32'sh8000_0000;
    localparam logic signed [slir_pkg::DATA_W-1:0] VAL_MAX = 32'sh7FFF_FFFF;

    // ------------------------------------------------------------------
    // Clock, reset and block ports
    // ------------------------------------------------------------------
    logic             clk       = 1'b0;
    logic             rst_n     = 1'b0;
    logic             in_valid  = 1'b0;
    logic             in_ready;
    slir_pkg::in_t    in_data   = '0;
    logic             out_valid;
    logic             out_ready = 1'b0;
    slir_pkg::out_t   out_data;

    always #(CLK_PERIOD / 2) clk = ~clk;

    sorted_list_insert_rotate #(
        .DEPTH(LIST_DEPTH)
    ) DUT (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .in_data   (in_data),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .out_data  (out_data)
    );

    // ------------------------------------------------------------------
    // Bench state
    // ------------------------------------------------------------------
    slir_pkg::in_t                      pending_items[$];   // transactions not yet offered
    slir_pkg::out_t                     awaited_results[$]; // results the block still owes
    logic signed [slir_pkg::DATA_W-1:0] list_cells[LIST_DEPTH];
    int unsigned                        list_len        = 0;
    int unsigned                        inserts_queued  = 0;
    int                                 send_idle_pct   = 0;
    int                                 recv_stall_pct  = 0;
    int                                 hold_off_req    = 0;
    int                                 hold_off_done   = 0;
    int                                 hold_off_left   = 0;
    int                                 fail_count      = 0;

    // ------------------------------------------------------------------
    // List image: apply one accepted transaction and queue its results
    // ------------------------------------------------------------------
    function automatic void await_result(logic [2:0] status,
                                         logic signed [slir_pkg::DATA_W-1:0] entry,
                                         logic last);
        slir_pkg::out_t res;
        res.status = status;
        res.entry  = entry;
        res.last   = last;
        awaited_results.push_back(res);
    endfunction

    function automatic void track_list_op(slir_pkg::in_t item);
        logic signed [slir_pkg::DATA_W-1:0] rotated[LIST_DEPTH];
        int unsigned                        slot;
        int unsigned                        half;
        case (item.mode)
            slir_pkg::MODE_INSERT:
            begin
                if (list_len >= LIST_DEPTH)
                begin
                    // Full store: drop the value, list unchanged
                    await_result(slir_pkg::ST_FULL, '0, 1'b1);
                end
                else
                begin
                    // Place ahead of entry 0 only if entry 0 is greater;
                    // otherwise scan from index 1 for the first entry that
                    // is not smaller than the value
                    if (list_len == 0 || $signed(item.value) < $signed(list_cells[0]))
                        slot = 0;
                    else
                    begin
                        slot = 1;
                        while (slot < list_len &&
                               $signed(list_cells[slot]) < $signed(item.value))
                            slot++;
                    end
                    for (int i = list_len; i > slot; i--)
                        list_cells[i] = list_cells[i - 1];
                    list_cells[slot] = item.value;
                    list_len++;
                    await_result(slir_pkg::ST_INSERTED, '0, 1'b1);
                end
            end
            slir_pkg::MODE_DISPLAY:
            begin
                if (list_len == 0)
                    await_result(slir_pkg::ST_EMPTY, '0, 1'b1);
                else
                    for (int i = 0; i < list_len; i++)
                        await_result(slir_pkg::ST_SHOWN, list_cells[i], i == list_len - 1);
            end
            slir_pkg::MODE_ROTATE:
            begin
                // Move the upper half (from floor(n/2)) ahead of the lower
                // half; fewer than two entries stay as they are
                if (list_len >= 2)
                begin
                    half = list_len / 2;
                    for (int i = 0; i < list_len; i++)
                        rotated[i] = list_cells[(i + half) % list_len];
                    for (int i = 0; i < list_len; i++)
                        list_cells[i] = rotated[i];
                end
                await_result(slir_pkg::ST_ROTATED, '0, 1'b1);
            end
            default:
            begin
                // Unused mode: no result, no change
            end
        endcase
    endfunction

    // ------------------------------------------------------------------
    // Driver: offer pending items, hold valid and payload until accepted
    // ------------------------------------------------------------------
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid <= 1'b0;
            in_data  <= '0;
        end
        else
        begin
            // Update the list image on every accepted transaction
            if (in_valid && in_ready)
                track_list_op(in_data);
            // Advance only when the slot is free; otherwise hold
            if (!in_valid || in_ready)
            begin
                if (pending_items.size() > 0 && $urandom_range(99) >= send_idle_pct)
                begin
                    in_valid <= 1'b1;
                    in_data  <= pending_items.pop_front();
                end
                else
                    in_valid <= 1'b0;
            end
        end
    end

    // ------------------------------------------------------------------
    // Monitor: check each result, drive ready with stalls and hold-off
    // ------------------------------------------------------------------
    always @(posedge clk or negedge rst_n)
    begin
        slir_pkg::out_t want;
        if (!rst_n)
        begin
            out_ready     <= 1'b0;
            hold_off_left <= 0;
            hold_off_done <= 0;
        end
        else
        begin
            if (out_valid && out_ready)
            begin
                if (awaited_results.size() == 0)
                begin
                    $display("%0t: unexpected result: status %0d entry %0d last %0d",
                             $time, out_data.status, out_data.entry, out_data.last);
                    fail_count++;
                end
                else
                begin
                    want = awaited_results.pop_front();
                    if (out_data.status !== want.status)
                    begin
                        $display("%0t: status mismatch: expected %0d, actual %0d",
                                 $time, want.status, out_data.status);
                        fail_count++;
                    end
                    if (out_data.entry !== want.entry)
                    begin
                        $display("%0t: entry mismatch: expected %0d, actual %0d",
                                 $time, want.entry, out_data.entry);
                        fail_count++;
                    end
                    if (out_data.last !== want.last)
                    begin
                        $display("%0t: last mismatch: expected %0d, actual %0d",
                                 $time, want.last, out_data.last);
                        fail_count++;
                    end
                end
            end
            // Start a long hold-off on request; count it down here
            if (hold_off_req != hold_off_done)
            begin
                hold_off_done <= hold_off_req;
                hold_off_left <= HOLD_OFF_CYCLES;
                out_ready     <= 1'b0;
            end
            else if (hold_off_left != 0)
            begin
                hold_off_left <= hold_off_left - 1;
                out_ready     <= 1'b0;
            end
            else
                out_ready <= ($urandom_range(99) >= recv_stall_pct);
        end
    end

    // ------------------------------------------------------------------
    // Stimulus helpers
    // ------------------------------------------------------------------
    task automatic queue_item(logic [1:0] mode, logic signed [slir_pkg::DATA_W-1:0] value);
        slir_pkg::in_t item;
        item.mode  = mode;
        item.value = value;
        if (mode == slir_pkg::MODE_INSERT)
            inserts_queued++;
        pending_items.push_back(item);
    endtask

    // Mix small values, extremes and full-range values so equal entries and ties show up often
    function automatic logic signed [slir_pkg::DATA_W-1:0] pick_value();
        logic signed [slir_pkg::DATA_W-1:0] val;
        case ($urandom_range(3))
            0: val = $urandom_range(16) - 8;
            1:
            begin
                case ($urandom_range(5))
                    0: val = VAL_MIN;
                    1: val = VAL_MAX;
                    2: val = VAL_MIN + 1;
                    3: val = VAL_MAX - 1;
                    4: val = -1;
                    default: val = '0;
                endcase
            end
            default: val = $urandom();
        endcase
        return val;
    endfunction

    // Queue n counted transactions; unused-mode items ride along uncounted.
    // Keep inserts sparse while the list grows so displays and rotates
    // see every occupancy on the way up.
    task automatic queue_random_items(int n);
        int          counted;
        int unsigned pick;
        counted = 0;
        while (counted < n)
        begin
            pick = $urandom_range(99);
            if (pick < 4)
                queue_item(MODE_UNUSED, $urandom());
            else
            begin
                counted++;
                if (pick < ((inserts_queued < LIST_DEPTH) ? 30 : 45))
                    queue_item(slir_pkg::MODE_INSERT, pick_value());
                else if (pick < 70)
                    queue_item(slir_pkg::MODE_DISPLAY, $urandom());
                else
                    queue_item(slir_pkg::MODE_ROTATE, $urandom());
            end
        end
    endtask

    // Wait until every item is taken and every result has come back
    task automatic wait_drained();
        while (pending_items.size() > 0 || in_valid || awaited_results.size() > 0)
            @(negedge clk);
    endtask

    task automatic run_phase(int send_pct, int recv_pct, bit with_hold_off);
        @(negedge clk);
        send_idle_pct  = send_pct;
        recv_stall_pct = recv_pct;
        if (with_hold_off)
            hold_off_req++;
        queue_random_items(PHASE_ITEMS);
        wait_drained();
    endtask

    // ------------------------------------------------------------------
    // Sequence: reset, directed cases, random phases, final check
    // ------------------------------------------------------------------
    initial
    begin
        repeat (9) @(posedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        // Directed: empty display, short rotates, extremes, ties, odd-count
        // rotates, the unused mode
        queue_item(slir_pkg::MODE_DISPLAY, '0);
        queue_item(slir_pkg::MODE_ROTATE, '1);
        queue_item(MODE_UNUSED, '1);
        queue_item(slir_pkg::MODE_INSERT, '0);
        queue_item(slir_pkg::MODE_ROTATE, '0);
        queue_item(slir_pkg::MODE_DISPLAY, '0);
        queue_item(slir_pkg::MODE_INSERT, VAL_MIN);
        queue_item(slir_pkg::MODE_INSERT, VAL_MAX);
        queue_item(slir_pkg::MODE_INSERT, VAL_MIN);   // equal to entry 0
        queue_item(slir_pkg::MODE_INSERT, '0);        // equal to a later entry
        queue_item(slir_pkg::MODE_DISPLAY, '0);
        queue_item(slir_pkg::MODE_ROTATE, '0);        // odd count
        queue_item(slir_pkg::MODE_DISPLAY, '0);
        queue_item(slir_pkg::MODE_INSERT, VAL_MAX);   // entry 0 is smaller; equal to a later entry
        queue_item(slir_pkg::MODE_INSERT, -1);
        queue_item(slir_pkg::MODE_ROTATE, '0);        // odd count
        queue_item(slir_pkg::MODE_DISPLAY, '0);
        wait_drained();

        // Random phases: no idling with a long output hold-off, sender
        // idle, receiver stalling, both
        run_phase(0, 0, 1'b1);
        run_phase(49, 0, 1'b0);
        run_phase(0, 49, 1'b0);
        run_phase(15, 15, 1'b0);

        // Let any stray result surface before judging
        repeat (SETTLE_CYCLES) @(negedge clk);
        if (fail_count == 0 && awaited_results.size() == 0)
            $display("PASS");
        else
            $display("FAIL");
        $finish;
    end

    // Watchdog
    initial
    begin
        #(CLK_PERIOD * 800000);
        $display("FAIL");
        $finish;
    end

endmodule
